### rtl/jsu_pkg.sv
// Shared types for the JSON string unescape unit.
// Holds the decoded request format passed from the front end to the back end.
// No dependencies.
package jsu_pkg;

  // Result kinds as they appear on the output tuser field
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // What the main part of a request carries
  typedef enum logic [1:0] {
    M_RAW   = 2'd0,  // one byte copied as is
    M_CP    = 2'd1,  // code point to be UTF-8 encoded
    M_CLOSE = 2'd2,  // string closed
    M_ERROR = 2'd3   // error report
  } main_t;

  localparam int unsigned CP_W = 21;

  // One decoded request: an optional U+FFFD ahead of the main part
  typedef struct packed {
    logic              pre_fffd;
    main_t             mtype;
    logic [CP_W-1:0]   val;
  } cmd_t;

  localparam logic [CP_W-1:0] CP_REPL = 21'h00FFFD;

endpackage

### rtl/jsu_front.sv
// Front end: escape and surrogate state machine of the unescape unit.
// Classifies each accepted text byte into at most one request.
// Depends on jsu_pkg.
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    in_byte,
  input  logic          first,
  input  logic          text_end,
  output logic          push,
  output jsu_pkg::cmd_t cmd
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_STR      = 3'd1,
    PH_ESC      = 3'd2,
    PH_HEX      = 3'd3,
    PH_HELD     = 3'd4,
    PH_HELD_ESC = 3'd5,
    PH_HEX2     = 3'd6
  } phase_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  phase_t      phase_r, phase_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  held_r, held_nxt;

  logic [4:0]  dig;
  logic [9:0]  esc;
  logic [15:0] hv;
  logic        err;

  // Digit value, bit 4 set when the byte is no hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  // {not an escape, is u, byte}
  function automatic logic [9:0] esc_map(input logic [7:0] c);
    logic [9:0] r;
    unique case (c)
      8'h6E:   r = {2'b00, 8'h0A};
      8'h74:   r = {2'b00, 8'h09};
      8'h72:   r = {2'b00, 8'h0D};
      8'h62:   r = {2'b00, 8'h08};
      8'h66:   r = {2'b00, 8'h0C};
      8'h2F:   r = {2'b00, 8'h2F};
      8'h5C:   r = {2'b00, 8'h5C};
      8'h22:   r = {2'b00, 8'h22};
      8'h75:   r = {2'b01, 8'h00};
      default: r = {2'b10, 8'h00};
    endcase
    return r;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    held_nxt  = held_r;
    push      = 1'b0;
    err       = 1'b0;
    cmd       = '{pre_fffd: 1'b0, mtype: M_RAW, val: '0};
    dig       = hex_val(in_byte);
    esc       = esc_map(in_byte);
    hv        = {acc_r, dig[3:0]};

    if (fire) begin
      if (text_end) begin
        err = first || (phase_r != PH_IDLE && phase_r != 3'd7);
      end else if (first) begin
        acc_nxt  = '0;
        cnt_nxt  = '0;
        held_nxt = '0;
        if (in_byte == CH_QUOTE) phase_nxt = PH_STR;
        else err = 1'b1;
      end else begin
        unique case (phase_r)
          PH_STR, PH_HELD: begin
            if (phase_r == PH_HELD && in_byte == CH_BSL) begin
              phase_nxt = PH_HELD_ESC;
            end else begin
              cmd.pre_fffd = (phase_r == PH_HELD);
              if (in_byte == CH_QUOTE) begin
                push      = 1'b1;
                cmd.mtype = M_CLOSE;
                phase_nxt = PH_IDLE;
              end else if (in_byte == CH_BSL) begin
                phase_nxt = PH_ESC;
              end else begin
                push      = 1'b1;
                cmd.val   = CP_W'(in_byte);
                phase_nxt = PH_STR;
              end
            end
          end
          PH_ESC, PH_HELD_ESC: begin
            if (esc[9]) begin
              err = 1'b1;
            end else if (esc[8]) begin
              acc_nxt   = '0;
              cnt_nxt   = '0;
              phase_nxt = (phase_r == PH_ESC) ? PH_HEX : PH_HEX2;
            end else begin
              push         = 1'b1;
              cmd.pre_fffd = (phase_r == PH_HELD_ESC);
              cmd.val      = CP_W'(esc[7:0]);
              phase_nxt    = PH_STR;
            end
          end
          PH_HEX, PH_HEX2: begin
            if (dig[4]) begin
              err = 1'b1;
            end else if (cnt_r != 2'd3) begin
              acc_nxt = {acc_r[7:0], dig[3:0]};
              cnt_nxt = cnt_r + 2'd1;
            end else begin
              acc_nxt  = '0;
              cnt_nxt  = '0;
              held_nxt = '0;
              if (phase_r == PH_HEX2 && hv >= 16'hDC00 && hv <= 16'hDFFF) begin
                // Pair complete: join into one supplementary code point
                push      = 1'b1;
                cmd.mtype = M_CP;
                cmd.val   = CP_W'({held_r, hv[9:0]}) + 21'h010000;
                phase_nxt = PH_STR;
              end else if (hv >= 16'hD800 && hv <= 16'hDBFF) begin
                held_nxt  = hv[9:0];
                phase_nxt = PH_HELD;
                if (phase_r == PH_HEX2) begin
                  push      = 1'b1;
                  cmd.mtype = M_CP;
                  cmd.val   = CP_REPL;
                end
              end else begin
                push         = 1'b1;
                cmd.pre_fffd = (phase_r == PH_HEX2);
                cmd.mtype    = M_CP;
                cmd.val      = CP_W'(hv);
                phase_nxt    = PH_STR;
              end
            end
          end
          default: ;
        endcase
      end

      if (err) begin
        push      = 1'b1;
        cmd       = '{pre_fffd: 1'b0, mtype: M_ERROR, val: '0};
        phase_nxt = PH_IDLE;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        held_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      cnt_r   <= '0;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

### rtl/jsu_queue.sv
// Request queue between front and back end of the unescape unit.
// Small register-based first-in first-out store of decoded requests.
// Depends on jsu_pkg.
module jsu_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output jsu_pkg::cmd_t rdata,
  output logic          nonempty
);
  import jsu_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == FULL_CNT);
  assign nonempty = (cnt_r != '0);
  assign rdata    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == LAST_PTR) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == LAST_PTR) ? '0 : rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> nonempty)
    else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= FULL_CNT)
    else $error("queue count out of range");

endmodule

### rtl/jsu_back.sv
// Back end of the unescape unit: expands requests into result bytes.
// UTF-8 encoder, replacement-character insertion and output register.
// Depends on jsu_pkg.
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_nonempty,
  input  jsu_pkg::cmd_t q_rdata,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output jsu_pkg::kind_t out_kind,
  output logic          out_last
);
  import jsu_pkg::*;

  logic        cur_valid_r;
  cmd_t        cur_r;
  logic [2:0]  idx_r;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  kind_t       out_kind_r;
  logic        out_last_r;

  logic [CP_W-1:0] cp;
  logic [7:0]  mb [4];
  logic [2:0]  mlen;
  kind_t       mkind;
  logic [2:0]  n;
  logic [2:0]  midx;
  logic [7:0]  sel_byte;
  kind_t       sel_kind;
  logic        sel_last;
  logic        out_load;

  // Encode the main part of the current request
  always_comb begin
    cp = (cur_r.val >= 21'h00D800 && cur_r.val <= 21'h00DFFF) ? CP_REPL : cur_r.val;
    mb[0] = 8'h00;
    mb[1] = 8'h00;
    mb[2] = 8'h00;
    mb[3] = 8'h00;
    mlen  = 3'd1;
    mkind = KIND_DATA;
    unique case (cur_r.mtype)
      M_RAW: mb[0] = cur_r.val[7:0];
      M_CP: begin
        if (cp < 21'h000080) begin
          mb[0] = cp[7:0];
        end else if (cp < 21'h000800) begin
          mb[0] = {3'b110, cp[10:6]};
          mb[1] = {2'b10, cp[5:0]};
          mlen  = 3'd2;
        end else if (cp < 21'h010000) begin
          mb[0] = {4'b1110, cp[15:12]};
          mb[1] = {2'b10, cp[11:6]};
          mb[2] = {2'b10, cp[5:0]};
          mlen  = 3'd3;
        end else begin
          mb[0] = {5'b11110, cp[20:18]};
          mb[1] = {2'b10, cp[17:12]};
          mb[2] = {2'b10, cp[11:6]};
          mb[3] = {2'b10, cp[5:0]};
          mlen  = 3'd4;
        end
      end
      M_CLOSE: mkind = KIND_CLOSE;
      default: mkind = KIND_ERROR;
    endcase
  end

  // Pick the result at the current index
  always_comb begin
    n    = cur_r.pre_fffd ? mlen + 3'd3 : mlen;
    midx = cur_r.pre_fffd ? idx_r - 3'd3 : idx_r;
    if (cur_r.pre_fffd && idx_r < 3'd3) begin
      sel_kind = KIND_DATA;
      unique case (idx_r[1:0])
        2'd0:    sel_byte = 8'hEF;
        2'd1:    sel_byte = 8'hBF;
        default: sel_byte = 8'hBD;
      endcase
    end else begin
      sel_kind = mkind;
      sel_byte = mb[midx[1:0]];
    end
    sel_last = (idx_r == n - 3'd1);
  end

  assign out_load = !out_valid_r || out_ready;
  assign q_pop    = q_nonempty && (!cur_valid_r || (out_load && sel_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= cur_valid_r;
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (cur_valid_r && out_load) begin
        if (sel_last) cur_valid_r <= 1'b0;
        else idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_rdata;
    if (out_load && cur_valid_r) begin
      out_byte_r <= sel_byte;
      out_kind_r <= sel_kind;
      out_last_r <= sel_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

  a_ctrl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != KIND_DATA |-> out_last_r && out_byte_r == 8'h00)
    else $error("close or error result not final or carries data");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> idx_r < n)
    else $error("result index beyond request length");
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r && cur_r.mtype == M_ERROR |-> !cur_r.pre_fffd)
    else $error("error request carries a replacement character");

endmodule

### rtl/json_string_unescape_utf8_unit.sv
// Top level of the JSON string unescape unit with UTF-8 output.
// Instantiates jsu_front, jsu_queue and jsu_back; types from jsu_pkg.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+----------------------------------------
//  in_     | in  | in_tvalid/tready  | tdata: in_byte; tuser: first, text_end
//  out_    | out | out_tvalid/tready | tdata: out_byte; tuser: kind; tlast
//
// Flow: the front end takes one text byte per cycle while the queue has room
// and turns it into at most one request in the same cycle. The back end sends
// one result per cycle while out_tready is high; a request expands into 1 to
// 6 results (4 for a supplementary code point, up to 6 for U+FFFD followed by
// a three-byte character), and the queue of QUEUE_DEPTH requests absorbs these
// bursts. Plain text flows at one byte per cycle while out_tready is high,
// through the queue, request register and output register. Reset (rst_n low,
// synchronous) empties the queue and returns the parser to idle. A stall on
// out_tready backs up through the queue; in_tready drops only when it is full.
module json_string_unescape_utf8_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [1:0] in_tuser,   // [0] first, [1] text_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast
);
  import jsu_pkg::*;

  logic  fire;
  logic  push;
  cmd_t  wcmd;
  cmd_t  rcmd;
  logic  q_full;
  logic  q_nonempty;
  logic  q_pop;
  kind_t kind;

  // Take a byte whenever the queue has room for its request
  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .in_byte  (in_tdata),
    .first    (in_tuser[0]),
    .text_end (in_tuser[1]),
    .push     (push),
    .cmd      (wcmd)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wdata    (wcmd),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (rcmd),
    .nonempty (q_nonempty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_rdata    (rcmd),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_kind   (kind),
    .out_last   (out_tlast)
  );

  assign out_tuser = kind;

endmodule
